// ===== design/gffra_pkg.sv =====
// Shared constants, command and status types for the grid first-fit rectangle allocator.
// Used by the interfaces, controller, datapath and top level.
package gffra_pkg;
	localparam int IN_W = 13;
	localparam int ID_OUT_W = 16;
	localparam int PX_W = 12;
	localparam int CFG_W = 8;
	localparam int BLOCK_SHIFT_DEF = 5;
	localparam int GRID_MAX_DEF = 128;
	localparam int ID_BITS_DEF = 16;
	localparam logic [CFG_W-1:0] SIDE_RESET = 8'd128;
	localparam logic STATUS_PLACED = 1'b0;
	localparam logic STATUS_NO_ROOM = 1'b1;

	typedef struct packed {
		logic start;
		logic row_init;
		logic row_begin;
		logic rd;
		logic acc;
		logic er_init;
		logic er_step;
		logic next_row;
		logic take;
		logic mark_wr;
		logic load_ok;
		logic load_fail;
	} gffra_cmd_t;

	typedef struct packed {
		logic fit_ok;
		logic row_over;
		logic bh_zero;
		logic rows_done;
		logic er_last;
		logic found;
		logic mark_last;
		logic out_busy;
	} gffra_sts_t;
endpackage

// ===== design/gffra_req_if.sv =====
// Request channel: valid/ready handshake carrying the image size in pixels.
// Depends on gffra_pkg.
interface gffra_req_if import gffra_pkg::*; ();
	logic valid;
	logic ready;
	logic [IN_W-1:0] width_px;
	logic [IN_W-1:0] height_px;
	modport source (output valid, width_px, height_px, input ready);
	modport sink (input valid, width_px, height_px, output ready);
endinterface

// ===== design/gffra_rsp_if.sv =====
// Result channel: valid/ready handshake carrying the placement result.
// Depends on gffra_pkg.
interface gffra_rsp_if import gffra_pkg::*; ();
	logic valid;
	logic ready;
	logic status;
	logic [ID_OUT_W-1:0] texture_id;
	logic [PX_W-1:0] left_px;
	logic [PX_W-1:0] top_px;
	logic [IN_W-1:0] rect_width;
	logic [IN_W-1:0] rect_height;
	modport source (output valid, status, texture_id, left_px, top_px, rect_width,
		rect_height, input ready);
	modport sink (input valid, status, texture_id, left_px, top_px, rect_width,
		rect_height, output ready);
endinterface

// ===== design/gffra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gffra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/gffra_ctrl.sv =====
// Controller state machine for the allocator: sequences row reads, window erosion,
// the column search and marking. Depends on gffra_pkg.
module gffra_ctrl import gffra_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input gffra_sts_t sts,
	output gffra_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_ROW, S_RD, S_ACC, S_ER_INIT, S_ER, S_FIND, S_MRD, S_MWR,
		S_OUT_OK, S_OUT_FAIL
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (!sts.fit_ok) begin
					state_d = S_OUT_FAIL;
				end else begin
					cmd.row_init = 1'b1;
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				if (sts.row_over) begin
					state_d = S_OUT_FAIL;
				end else begin
					cmd.row_begin = 1'b1;
					state_d = sts.bh_zero ? S_ER_INIT : S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.rows_done ? S_ER_INIT : S_RD;
			end
			S_ER_INIT: begin
				cmd.er_init = 1'b1;
				state_d = S_ER;
			end
			S_ER: begin
				cmd.er_step = 1'b1;
				if (sts.er_last) begin
					state_d = S_FIND;
				end
			end
			S_FIND: begin
				if (sts.found) begin
					cmd.take = 1'b1;
					state_d = sts.bh_zero ? S_OUT_OK : S_MRD;
				end else begin
					cmd.next_row = 1'b1;
					state_d = S_ROW;
				end
			end
			S_MRD: begin
				state_d = S_MWR;
			end
			S_MWR: begin
				cmd.mark_wr = 1'b1;
				state_d = sts.mark_last ? S_OUT_OK : S_MRD;
			end
			S_OUT_OK: begin
				if (!sts.out_busy) begin
					cmd.load_ok = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_OUT_FAIL: begin
				if (!sts.out_busy) begin
					cmd.load_fail = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== design/gffra_dp.sv =====
// Datapath of the allocator: occupancy row memory, row OR accumulator, run-of-free
// erosion unit, column search, marking, identifier counter and result register.
// Depends on gffra_pkg and gffra_ram.
module gffra_dp import gffra_pkg::*; #(
	parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF,
	parameter int GRID_MAX = GRID_MAX_DEF,
	parameter int ID_BITS = ID_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_W-1:0] cfg_wdata,
	input logic [IN_W-1:0] width_px,
	input logic [IN_W-1:0] height_px,
	input gffra_cmd_t cmd,
	output gffra_sts_t sts,
	input logic rsp_ready,
	output logic rsp_valid,
	output logic rsp_status,
	output logic [ID_OUT_W-1:0] rsp_texture_id,
	output logic [PX_W-1:0] rsp_left_px,
	output logic [PX_W-1:0] rsp_top_px,
	output logic [IN_W-1:0] rsp_rect_width,
	output logic [IN_W-1:0] rsp_rect_height
);
	localparam int BW_W = IN_W - BLOCK_SHIFT + 1;
	localparam int AW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
	localparam int GW = $clog2(GRID_MAX + 1) + 1;
	localparam int CW = ((BW_W > GW) ? BW_W : GW) + 1;
	localparam int KW = $clog2(BW_W + 1);
	localparam int RW = IN_W + BLOCK_SHIFT + 1;
	localparam int LW = AW + BLOCK_SHIFT + PX_W;
	localparam int IW = ID_BITS + ID_OUT_W;
	localparam logic [RW-1:0] ROUND = RW'((1 << BLOCK_SHIFT) - 1);

	logic [CFG_W-1:0] grid_side_q;
	logic [IN_W-1:0] w_q, h_q;
	logic [BW_W-1:0] bw_q, bh_q;
	logic [CW-1:0] side_q, oy_q, y_q, len_q;
	logic [KW-1:0] k_q;
	logic [GRID_MAX-1:0] acc_q, p_q, r_q, rv_q;
	logic [AW-1:0] ox_q;
	logic rd_valid_q, rd_row0_q;
	logic [ID_BITS-1:0] next_id_q;

	logic [RW-1:0] sum_w, sum_h;
	logic [8:0] g9;
	logic [CW-1:0] side_d, step, bh_c, oy_bh;
	logic [GRID_MAX-1:0] ram_rdata, row_data, side_mask, free_v, rmask;
	logic [AW-1:0] enc;
	logic [LW-1:0] left_w;
	logic [IW-1:0] id_w;

	// Lowest set bit of the window vector gives the leftmost fitting origin.
	function automatic logic [AW-1:0] first_set(input logic [GRID_MAX-1:0] v);
		logic [AW-1:0] idx;
		idx = '0;
		for (int i = GRID_MAX - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = AW'(i);
			end
		end
		return idx;
	endfunction

	assign sum_w = RW'(width_px) + ROUND;
	assign sum_h = RW'(height_px) + ROUND;
	assign g9 = 9'(grid_side_q);
	assign side_d = (g9 > 9'(GRID_MAX)) ? CW'(GRID_MAX) : CW'(grid_side_q);
	assign bh_c = CW'(bh_q);
	assign oy_bh = oy_q + bh_c;
	assign step = CW'(1) << k_q;
	assign side_mask = ~({GRID_MAX{1'b1}} << side_q);
	assign free_v = ~acc_q & side_mask;
	assign rmask = (~({GRID_MAX{1'b1}} << bw_q)) << ox_q;
	assign row_data = rd_valid_q ? ram_rdata : (rd_row0_q ? GRID_MAX'(1) : '0);
	assign enc = first_set(r_q);
	assign id_w = IW'(next_id_q);
	assign left_w = LW'(ox_q) << BLOCK_SHIFT;

	assign sts.fit_ok = (side_q != '0) && (CW'(bw_q) <= side_q) && (bh_c <= side_q);
	assign sts.row_over = oy_bh > side_q;
	assign sts.bh_zero = (bh_q == '0);
	assign sts.rows_done = (y_q == oy_bh);
	assign sts.er_last = (k_q == KW'(BW_W - 1));
	assign sts.found = |r_q;
	assign sts.mark_last = ((y_q + CW'(1)) == oy_bh);
	assign sts.out_busy = rsp_valid;

	gffra_ram #(.WIDTH(GRID_MAX), .DEPTH(GRID_MAX), .AW(AW)) u_map (
		.clk(clk),
		.we(cmd.mark_wr),
		.waddr(y_q[AW-1:0]),
		.wdata(row_data | rmask),
		.raddr(y_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_RESET;
			rv_q <= '0;
			next_id_q <= ID_BITS'(1);
			rsp_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				grid_side_q <= cfg_wdata;
			end
			if (cmd.mark_wr) begin
				rv_q[y_q[AW-1:0]] <= 1'b1;
			end
			if (cmd.load_ok) begin
				next_id_q <= next_id_q + ID_BITS'(1);
			end
			if (cmd.load_ok || cmd.load_fail) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_valid_q <= rv_q[y_q[AW-1:0]];
		rd_row0_q <= (y_q == '0);
		if (cmd.start) begin
			w_q <= width_px;
			h_q <= height_px;
			bw_q <= BW_W'(sum_w >> BLOCK_SHIFT);
			bh_q <= BW_W'(sum_h >> BLOCK_SHIFT);
			side_q <= side_d;
		end
		if (cmd.row_init) begin
			oy_q <= '0;
		end else if (cmd.next_row) begin
			oy_q <= oy_q + CW'(1);
		end
		if (cmd.row_begin || cmd.take) begin
			y_q <= oy_q;
		end else if (cmd.rd || cmd.mark_wr) begin
			y_q <= y_q + CW'(1);
		end
		if (cmd.row_begin) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_q | row_data;
		end
		// Windows of free blocks are built by doubling: p covers 2^k columns,
		// r covers the bits of the block width taken so far.
		if (cmd.er_init) begin
			p_q <= free_v;
			r_q <= '1;
			len_q <= '0;
			k_q <= '0;
		end else if (cmd.er_step) begin
			p_q <= p_q & (p_q >> step);
			if (bw_q[k_q]) begin
				r_q <= r_q & (p_q >> len_q);
				len_q <= len_q + step;
			end
			k_q <= k_q + KW'(1);
		end
		if (cmd.take) begin
			ox_q <= enc;
		end
		if (cmd.load_ok) begin
			rsp_status <= STATUS_PLACED;
			rsp_texture_id <= id_w[ID_OUT_W-1:0];
			rsp_left_px <= left_w[PX_W-1:0];
			rsp_top_px <= PX_W'(LW'(oy_q[AW-1:0]) << BLOCK_SHIFT);
			rsp_rect_width <= w_q;
			rsp_rect_height <= h_q;
		end else if (cmd.load_fail) begin
			rsp_status <= STATUS_NO_ROOM;
			rsp_texture_id <= '0;
			rsp_left_px <= '0;
			rsp_top_px <= '0;
			rsp_rect_width <= '0;
			rsp_rect_height <= '0;
		end
	end
endmodule

// ===== design/grid_first_fit_rect_allocator_core.sv =====
// Top level of the grid first-fit rectangle allocator: controller, datapath, ports.
// Depends on gffra_pkg, gffra_req_if, gffra_rsp_if, gffra_ctrl and gffra_dp.
//
// Each request transaction carries an image size in pixels; both sides are rounded up
// to whole blocks and the occupancy grid is searched top to bottom, left to right for
// the first free rectangle, which is then marked used and returned with a new texture
// identifier (status 1 and zero fields when nothing fits). One request is handled at a
// time. For each candidate origin row the block reads the bh rows it covers from the
// row memory, runs 14 - BLOCK_SHIFT erosion steps and a column search; a placement
// then reads and rewrites each marked row. After reset the block is ready at once;
// block 0,0 starts used and identifiers start at 1. The user must write the grid side
// register only while idle; the block itself does not enforce this.
module grid_first_fit_rect_allocator_core import gffra_pkg::*; #(
	parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF,
	parameter int GRID_MAX = GRID_MAX_DEF,
	parameter int ID_BITS = ID_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_W-1:0] cfg_wdata,
	gffra_req_if.sink req,
	gffra_rsp_if.source rsp
);
	gffra_cmd_t cmd;
	gffra_sts_t sts;
	logic req_ready;

	assign req.ready = req_ready;

	gffra_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req_ready),
		.sts(sts),
		.cmd(cmd)
	);

	gffra_dp #(.BLOCK_SHIFT(BLOCK_SHIFT), .GRID_MAX(GRID_MAX), .ID_BITS(ID_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.width_px(req.width_px),
		.height_px(req.height_px),
		.cmd(cmd),
		.sts(sts),
		.rsp_ready(rsp.ready),
		.rsp_valid(rsp.valid),
		.rsp_status(rsp.status),
		.rsp_texture_id(rsp.texture_id),
		.rsp_left_px(rsp.left_px),
		.rsp_top_px(rsp.top_px),
		.rsp_rect_width(rsp.rect_width),
		.rsp_rect_height(rsp.rect_height)
	);

	// A second request is never taken in the cycle after one was accepted.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req_ready) |=> !req_ready)
		else $error("request accepted while busy");

	// A result is only loaded when the result register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_ok || cmd.load_fail) |-> !sts.out_busy)
		else $error("result register overwritten");

	// Placed and no-room results are never loaded together.
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_ok && cmd.load_fail))
		else $error("two outcomes for one request");

	// Each loaded result shows up as valid in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_ok || cmd.load_fail) |=> rsp.valid)
		else $error("loaded result not presented");
endmodule

// ===== sim/tb_grid_first_fit_rect_allocator_core.sv =====
// Self-checking testbench for grid_first_fit_rect_allocator_core.
// Depends on gffra_pkg, gffra_req_if, gffra_rsp_if and the allocator RTL; a scoreboard
// class mirrors the occupancy grid and checks every placement result in order.
module tb_grid_first_fit_rect_allocator_core;
	import gffra_pkg::*;

	localparam int SHIFT = 5;
	localparam int SIDE_MAX = 128;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic status;
		logic [ID_OUT_W-1:0] texture_id;
		logic [PX_W-1:0] left_px;
		logic [PX_W-1:0] top_px;
		logic [IN_W-1:0] rect_width;
		logic [IN_W-1:0] rect_height;
	} placement_t;

	class placement_scoreboard;
		logic [SIDE_MAX-1:0] grid_rows [SIDE_MAX];
		logic [ID_OUT_W-1:0] next_tex_id;
		int unsigned grid_side;
		placement_t pending_q [$];
		int mismatches;

		function new();
			foreach (grid_rows[i])
				grid_rows[i] = '0;
			grid_rows[0][0] = 1'b1;
			next_tex_id = 1;
			grid_side = SIDE_RESET;
			mismatches = 0;
		endfunction

		function bit area_free(int ox, int oy, int bw, int bh);
			logic [SIDE_MAX:0] span;
			span = (({{SIDE_MAX{1'b0}}, 1'b1}) << bw) - 1;
			for (int y = oy; y < oy + bh; y++)
				if ((({1'b0, grid_rows[y]} >> ox) & span) != 0)
					return 0;
			return 1;
		endfunction

		// Works out the placement for one accepted request and updates the grid.
		function void note_request(logic [IN_W-1:0] w, logic [IN_W-1:0] h);
			placement_t r;
			int bw, bh, side, fx, fy;
			bit found;
			bw = (int'(w) + (1 << SHIFT) - 1) >> SHIFT;
			bh = (int'(h) + (1 << SHIFT) - 1) >> SHIFT;
			side = grid_side > SIDE_MAX ? SIDE_MAX : grid_side;
			found = 0;
			fx = 0;
			fy = 0;
			if (side > 0 && bw <= side && bh <= side) begin
				for (int oy = 0; oy + bh <= side && !found; oy++)
					for (int ox = 0; ox + bw <= side && !found; ox++)
						if (area_free(ox, oy, bw, bh)) begin
							found = 1;
							fx = ox;
							fy = oy;
						end
			end
			r = '0;
			if (!found) begin
				r.status = STATUS_NO_ROOM;
			end else begin
				for (int y = fy; y < fy + bh; y++)
					for (int x = fx; x < fx + bw; x++)
						grid_rows[y][x] = 1'b1;
				r.status = STATUS_PLACED;
				r.texture_id = next_tex_id;
				r.left_px = PX_W'(fx << SHIFT);
				r.top_px = PX_W'(fy << SHIFT);
				r.rect_width = w;
				r.rect_height = h;
				next_tex_id = next_tex_id + 1'b1;
			end
			pending_q.push_back(r);
		endfunction

		function void check_result(placement_t got);
			placement_t exp_r;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result transaction %p", got);
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.status !== exp_r.status || got.texture_id !== exp_r.texture_id ||
				got.left_px !== exp_r.left_px || got.top_px !== exp_r.top_px ||
				got.rect_width !== exp_r.rect_width ||
				got.rect_height !== exp_r.rect_height) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result mismatch\n  expected %p\n  actual   %p",
						exp_r, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	bit idle_on;
	int ready_hold;
	placement_t rsp_word;

	gffra_req_if req_ch();
	gffra_rsp_if rsp_ch();
	placement_scoreboard sb;

	grid_first_fit_rect_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		longint cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb_grid_first_fit_rect_allocator_core failed");
				$finish;
			end
		end
	end

	// Result side: accept transactions and stall in random bursts.
	initial begin
		rsp_ch.ready <= 1'b0;
		ready_hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (rsp_ch.valid && rsp_ch.ready) begin
					rsp_word.status = rsp_ch.status;
					rsp_word.texture_id = rsp_ch.texture_id;
					rsp_word.left_px = rsp_ch.left_px;
					rsp_word.top_px = rsp_ch.top_px;
					rsp_word.rect_width = rsp_ch.rect_width;
					rsp_word.rect_height = rsp_ch.rect_height;
					sb.check_result(rsp_word);
				end
				if (ready_hold > 0) begin
					ready_hold--;
					rsp_ch.ready <= 1'b0;
				end else if (idle_on && $urandom_range(0, 6) == 0) begin
					ready_hold = $urandom_range(1, 5) - 1;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	task automatic send_request(logic [IN_W-1:0] w, logic [IN_W-1:0] h);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.width_px <= w;
		req_ch.height_px <= h;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(w, h);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_side(int unsigned side);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(side);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.grid_side = side;
		@(posedge clk);
	endtask

	task automatic random_requests(int unsigned side, int count);
		int unsigned span, w, h;
		span = (side > SIDE_MAX ? SIDE_MAX : side) << SHIFT;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					w = $urandom_range(0, 4096);
					h = $urandom_range(0, 4096);
				end
				1, 2: begin
					w = $urandom_range(0, span);
					h = $urandom_range(0, span);
				end
				default: begin
					w = $urandom_range(0, span < 256 ? span : 256);
					h = $urandom_range(0, span < 128 ? span : 128);
				end
			endcase
			send_request(IN_W'(w), IN_W'(h));
		end
	endtask

	initial begin
		int unsigned sides [10];
		int counts [10];
		sides = '{4, 8, 12, 16, 24, 32, 48, 64, 128, 20};
		counts = '{120, 120, 120, 120, 100, 100, 60, 50, 40, 70};
		sb = new();
		idle_on = 1'b1;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.width_px <= '0;
		req_ch.height_px <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset grid side.
		send_request(0, 0);
		send_request(0, 4096);
		send_request(4096, 0);
		send_request(4096, 4096);
		send_request(4096, 32);
		send_request(1, 1);
		send_request(32, 32);
		send_request(33, 1);
		send_request(4095, 4095);
		send_request(1, 4096);
		send_request(4095, 31);
		send_request(31, 4095);
		// Pause until everything is out, then resume.
		drain_results();
		send_request(64, 64);
		write_side(0);
		send_request(0, 0);
		send_request(1, 1);
		write_side(1);
		send_request(1, 1);
		send_request(0, 5);
		send_request(32, 0);
		write_side(255);
		send_request(96, 64);
		send_request(4096, 1);
		write_side(200);
		send_request(4000, 33);

		for (int p = 0; p < 10; p++) begin
			write_side(sides[p]);
			if (p == 9)
				idle_on = 1'b0;
			random_requests(sides[p], counts[p]);
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb_grid_first_fit_rect_allocator_core passed");
		else
			$display("tb_grid_first_fit_rect_allocator_core failed");
		$finish;
	end
endmodule
